// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/swra_pkg.sv =====
// Types, constants and codes for the stack with running mean.
`default_nettype none

package swra_pkg;

  localparam int STACK_DEPTH        = 16;
  localparam int MEAN_FRACTION_BITS = 8;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SUM_W  = DATA_W + PTR_W;
  localparam int MEAN_W = 40;
  localparam int DIVD_W = SUM_W + MEAN_FRACTION_BITS;
  localparam int STEP_W = $clog2(DIVD_W);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POP_EMPTY  = 2'd1,
    STAT_PUSH_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic                     is_empty;
    logic [4:0]               entry_count;
    logic signed [MEAN_W-1:0] mean_fixed;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/swra_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module swra_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swra_div.sv =====
// Iterative restoring divider: (sum << frac bits) / count, truncated toward zero.
`default_nettype none

module swra_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [swra_pkg::SUM_W-1:0]  dividend,
  input  wire logic [swra_pkg::CNT_W-1:0]         divisor,
  output      swra_pkg::div_status_t              stat,
  output      logic signed [swra_pkg::MEAN_W-1:0] quotient
);

  localparam int DW = swra_pkg::DIVD_W;
  localparam int CW = swra_pkg::CNT_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [swra_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [DW-1:0]                 acc_r, acc_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [CW-1:0]                 dsr_r, dsr_nxt;
  logic                          neg_r, neg_nxt;
  logic [swra_pkg::SUM_W-1:0]    mag;
  logic [CW:0]                   shifted;
  logic [CW:0]                   trial;
  logic [DW-1:0]                 signed_q;

  assign mag     = dividend[swra_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign shifted = {rem_r, acc_r[DW-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      acc_nxt  = {mag, {swra_pkg::MEAN_FRACTION_BITS{1'b0}}};
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      neg_nxt  = dividend[swra_pkg::SUM_W-1];
    end else if (busy_r) begin
      // one quotient bit per cycle; remainder stays below a nonzero divisor
      if (!trial[CW]) begin
        rem_nxt = trial[CW-1:0];
        acc_nxt = {acc_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CW-1:0];
        acc_nxt = {acc_r[DW-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == swra_pkg::STEP_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
  end

  assign signed_q  = neg_r ? (~acc_r + 1'b1) : acc_r;
  assign quotient  = signed_q[swra_pkg::MEAN_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/stack_with_running_average_core.sv =====
// Top level: LIFO stack in RAM with count, running sum and fixed-point mean.
//
//   port group | dir | handshake           | payload
//   in_        | in  | in_valid/in_ready   | swra_pkg::in_item_t (operation, push_value)
//   out_       | out | out_valid/out_ready | swra_pkg::out_item_t (top, empty, count, mean, status)
//
// Each request passes through accept, a RAM read state that also starts the
// bit-serial mean divider, the divider steps (one quotient bit each), latching
// the quotient, and loading the output register. The divider dominates.
// Reset clears count, sum, FSM and output valid; the entry RAM is not cleared.
// A request is accepted while a previous result still waits in the output
// register; a stalled output holds the FSM in its last state until it drains.
`default_nettype none

module stack_with_running_average_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire swra_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      swra_pkg::out_item_t out_data
);

  `include "assert_macros.svh"

  localparam int DW = swra_pkg::DATA_W;
  localparam int CW = swra_pkg::CNT_W;
  localparam int SW = swra_pkg::SUM_W;

  swra_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic signed [SW-1:0]          sum_r, sum_nxt;
  logic signed [DW-1:0]          top_r, top_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic signed [swra_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic                          rd_pend_r;
  logic                          out_valid_r, out_valid_nxt;
  swra_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                          in_acc;
  logic                          div_start;
  logic                          out_load;
  logic                          ram_we;
  logic                          ram_re;
  logic [CW-1:0]                 rd_ptr;
  logic [DW-1:0]                 ram_rdata;
  logic                          is_full;
  logic                          is_empty;
  swra_pkg::div_status_t         div_stat;
  logic signed [swra_pkg::MEAN_W-1:0] div_q;

  assign in_acc   = in_valid && in_ready;
  assign is_full  = (count_r == CW'(swra_pkg::STACK_DEPTH));
  assign is_empty = (count_r == '0);
  // after a pop the new top sits two below the old count
  assign rd_ptr   = count_r - CW'(2);

  swra_ram #(
    .DEPTH (swra_pkg::STACK_DEPTH),
    .WIDTH (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[swra_pkg::PTR_W-1:0]),
    .wdata (in_data.push_value),
    .re    (ram_re),
    .raddr (rd_ptr[swra_pkg::PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  swra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swra_pkg::ST_IDLE: if (in_acc) state_nxt = swra_pkg::ST_READ;
      swra_pkg::ST_READ: state_nxt = swra_pkg::ST_DIV;
      swra_pkg::ST_DIV:  if (div_stat.done) state_nxt = swra_pkg::ST_OUT;
      swra_pkg::ST_OUT:  if (out_load) state_nxt = swra_pkg::ST_IDLE;
      default:           state_nxt = swra_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      swra_pkg::ST_IDLE: in_ready  = 1'b1;
      swra_pkg::ST_READ: div_start = 1'b1;
      swra_pkg::ST_OUT:  out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // stack update on accept; top entry is cached so only pops touch the read port
  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (in_acc) begin
      status_nxt = swra_pkg::STAT_OK;
      case (in_data.operation)
        swra_pkg::OP_PUSH: begin
          if (is_full) begin
            status_nxt = swra_pkg::STAT_PUSH_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + {{(SW-DW){in_data.push_value[DW-1]}}, in_data.push_value};
            top_nxt   = in_data.push_value;
          end
        end
        swra_pkg::OP_POP: begin
          if (is_empty) begin
            status_nxt = swra_pkg::STAT_POP_EMPTY;
          end else begin
            ram_re    = 1'b1;
            count_nxt = count_r - 1'b1;
            sum_nxt   = sum_r - {{(SW-DW){top_r[DW-1]}}, top_r};
          end
        end
        default: ;
      endcase
    end
    if (state_r == swra_pkg::ST_READ && rd_pend_r) begin
      top_nxt = ram_rdata;
    end
  end

  always_comb begin
    mean_nxt = mean_r;
    if (state_r == swra_pkg::ST_DIV && div_stat.done) begin
      mean_nxt = div_q;
    end
  end

  always_comb begin
    out_data_nxt             = out_data_r;
    out_valid_nxt            = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.top_value   = is_empty ? '0 : top_r;
      out_data_nxt.is_empty    = is_empty;
      out_data_nxt.entry_count = 5'(count_r);
      out_data_nxt.mean_fixed  = is_empty ? '0 : mean_r;
      out_data_nxt.status      = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swra_pkg::ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      rd_pend_r   <= ram_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    status_r   <= status_nxt;
    mean_r     <= mean_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_count_bound, count_r > CW'(swra_pkg::STACK_DEPTH), "entry count above depth")
  `ASSERT_NEVER(a_acc_div_busy, in_acc && div_stat.busy, "request accepted during divide")
  `ASSERT_CLK(a_done_in_div, div_stat.done |-> state_r == swra_pkg::ST_DIV, "divider done outside wait")
  `ASSERT_CLK(a_rd_then_start, rd_pend_r |-> state_r == swra_pkg::ST_READ, "read data out of step")
  `ASSERT_CLK(a_load_valid, out_load |=> out_valid_r, "result load did not raise valid")

endmodule

`default_nettype wire

// ===== verif/stack_with_running_average_core_tb.sv =====
// Testbench for the stack with running mean: driver, monitor and stack/mean predictor.
`timescale 1ns / 1ps

module stack_with_running_average_core_tb;
  import swra_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_CYCLES     = 400;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stack_with_running_average_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow copy of the stack contents, depth and sum.
  logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int                       shadow_depth = 0;
  longint                   shadow_sum   = 0;

  in_item_t  pending_requests [$];
  out_item_t expected_results [$];
  out_item_t want;

  bit req_taken      = 1'b0;
  int requests_taken = 0;
  int mismatch_count = 0;
  int gap_left       = 0;
  int burst_left     = 0;
  int stall_mode     = 0;
  int stall_left     = 0;
  bit ready_bit      = 1'b1;
  bit drain_hold     = 1'b0;

  // Applies one request to the shadow stack and returns the expected result item.
  function automatic out_item_t stack_apply(in_item_t req);
    out_item_t res;
    longint    scaled;
    res = '0;
    res.status = STAT_OK;
    case (req.operation)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          res.status = STAT_PUSH_FULL;
        end else begin
          shadow_stack[shadow_depth] = req.push_value;
          shadow_depth++;
          shadow_sum += longint'(req.push_value);
        end
      end
      OP_POP: begin
        if (shadow_depth == 0) begin
          res.status = STAT_POP_EMPTY;
        end else begin
          shadow_depth--;
          shadow_sum -= longint'(shadow_stack[shadow_depth]);
        end
      end
      default: ;  // query and the unused code leave the stack alone
    endcase
    if (shadow_depth > 0) begin
      res.top_value = shadow_stack[shadow_depth-1];
      // signed longint division truncates toward zero
      scaled = (shadow_sum * (longint'(1) << MEAN_FRACTION_BITS)) / longint'(shadow_depth);
      res.mean_fixed = scaled[MEAN_W-1:0];
    end
    res.is_empty    = (shadow_depth == 0);
    res.entry_count = 5'(shadow_depth);
    return res;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
    $display("mismatch on %s: got %0h, expected %0h (request %0d)",
             field, got, exp_val, requests_taken);
    mismatch_count++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3, 4:    return $urandom_range(0, 31) - 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_request(logic [1:0] op, logic [DATA_W-1:0] value);
    in_item_t req;
    req.operation  = op;
    req.push_value = value;
    pending_requests = {pending_requests, req};
  endfunction

  // Driver: bursts of requests separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                   : $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: switches among four ready modes, from always ready to rarely ready.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       ready_bit = 1'b1;
      1:       ready_bit = $urandom_range(0, 1);
      2:       ready_bit = ($urandom_range(0, 3) != 0);
      default: ready_bit = ($urandom_range(0, 7) == 0);
    endcase
    out_ready <= ready_bit && !drain_hold;
  end

  // Long output hold-offs so the block backs up and stalls its input.
  initial begin
    while (requests_taken < 300) @(negedge clk);
    drain_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    drain_hold = 1'b0;
    while (requests_taken < 1000) @(negedge clk);
    drain_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    drain_hold = 1'b0;
  end

  // Monitor: check results, then predict for the request taken at this edge.
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", 64'(out_data.top_value), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.top_value !== want.top_value)
          note_mismatch("top_value", 64'(out_data.top_value), 64'(want.top_value));
        if (out_data.is_empty !== want.is_empty)
          note_mismatch("is_empty", 64'(out_data.is_empty), 64'(want.is_empty));
        if (out_data.entry_count !== want.entry_count)
          note_mismatch("entry_count", 64'(out_data.entry_count), 64'(want.entry_count));
        if (out_data.mean_fixed !== want.mean_fixed)
          note_mismatch("mean_fixed", 64'(out_data.mean_fixed), 64'(want.mean_fixed));
        if (out_data.status !== want.status)
          note_mismatch("status", 64'(out_data.status), 64'(want.status));
      end
    end
    if (req_taken) begin
      expected_results = {expected_results, stack_apply(in_data)};
      requests_taken++;
    end
  end

  initial begin
    #(CLK_HALF * 2 * 1_000_000);
    $display("[stack_with_running_average_core] ERROR");
    $finish;
  end

  initial begin
    bit push_heavy;
    int phase_left;
    int pick;

    // Directed: empty cases, the unused code, fill with extremes, push on full.
    add_request(OP_QUERY, 32'h1234_5678);
    add_request(OP_POP, 32'hffff_ffff);
    add_request(2'd3, 32'h8000_0000);
    for (int i = 0; i < 8; i++) add_request(OP_PUSH, 32'h7fff_ffff);
    for (int i = 0; i < 7; i++) add_request(OP_PUSH, 32'h8000_0000);
    add_request(OP_PUSH, 32'hffff_ffff);
    add_request(OP_PUSH, 32'h0000_0001);  // full, dropped
    add_request(OP_QUERY, 32'h0);
    add_request(OP_POP, 32'h0);
    add_request(OP_POP, 32'h0);
    add_request(2'd3, 32'h7fff_ffff);

    // Random: alternating push-heavy and pop-heavy stretches sweep the depth.
    push_heavy = 1'b1;
    phase_left = 0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (phase_left == 0) begin
        push_heavy = ~push_heavy;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 10)
        add_request(OP_QUERY, $urandom());
      else if (pick < 15)
        add_request(2'd3, $urandom());
      else if ((pick < 85) == push_heavy)
        add_request(OP_PUSH, pick_value());
      else
        add_request(OP_POP, $urandom());
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0)
      $display("[stack_with_running_average_core] OK");
    else
      $display("[stack_with_running_average_core] ERROR");
    $finish;
  end

endmodule
